/* rtl/core/lpg_pkg.sv */
`timescale 1ns / 1ps

package lpg_pkg;

	localparam int PANEL_SIZE  = 64;
	localparam int COORD_W     = 6;
	localparam int COLOR_W     = 8;
	localparam int ERR_W       = COORD_W + 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(PANEL_SIZE - 1);

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct packed {
		coord_t maj0;
		coord_t min0;
		coord_t maj1;
		coord_t dx;
		coord_t dy;
		logic   step_dn;
		logic   steep;
		color_t color;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAW
	} state_t;

	function automatic coord_t clamp_coord(input coord_t v);
		coord_t r;
		r = (v > COORD_MAX) ? COORD_MAX : v;
		return r;
	endfunction

endpackage

/* rtl/core/lpg_front.sv */
`timescale 1ns / 1ps

module lpg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lpg_pkg::coord_t start_x,
	input  lpg_pkg::coord_t start_y,
	input  lpg_pkg::coord_t end_x,
	input  lpg_pkg::coord_t end_y,
	input  lpg_pkg::color_t line_color,
	output logic            cmd_valid,
	input  logic            cmd_full,
	output lpg_pkg::cmd_t   cmd
);
	import lpg_pkg::*;

	logic   valid_s1;
	coord_t ax_s1, ay_s1, bx_s1, by_s1;
	color_t color_s1;

	logic   accept;
	coord_t adx, ady;
	logic   steep;
	coord_t a_maj, a_min, b_maj, b_min;
	logic   swap;

	assign full      = valid_s1 && cmd_full;
	assign accept    = push && !full;
	assign cmd_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!cmd_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_s1    <= clamp_coord(start_x);
			ay_s1    <= clamp_coord(start_y);
			bx_s1    <= clamp_coord(end_x);
			by_s1    <= clamp_coord(end_y);
			color_s1 <= line_color;
		end
	end

	// classify: steepness, endpoint order, deltas
	always_comb begin
		adx   = (bx_s1 > ax_s1) ? (bx_s1 - ax_s1) : (ax_s1 - bx_s1);
		ady   = (by_s1 > ay_s1) ? (by_s1 - ay_s1) : (ay_s1 - by_s1);
		steep = ady > adx;
		a_maj = steep ? ay_s1 : ax_s1;
		a_min = steep ? ax_s1 : ay_s1;
		b_maj = steep ? by_s1 : bx_s1;
		b_min = steep ? bx_s1 : by_s1;
		swap  = a_maj > b_maj;
		cmd.maj0    = swap ? b_maj : a_maj;
		cmd.min0    = swap ? b_min : a_min;
		cmd.maj1    = swap ? a_maj : b_maj;
		cmd.dx      = steep ? ady : adx;
		cmd.dy      = steep ? adx : ady;
		cmd.step_dn = swap ? (b_min >= a_min) : (a_min >= b_min);
		cmd.steep   = steep;
		cmd.color   = color_s1;
	end

endmodule

/* rtl/core/lpg_queue.sv */
`timescale 1ns / 1ps

module lpg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  lpg_pkg::cmd_t wr_data,
	output logic          q_full,
	input  logic          rd_en,
	output lpg_pkg::cmd_t rd_data,
	output logic          q_empty
);
	import lpg_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr, do_rd;

	assign q_full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/core/lpg_back.sv */
`timescale 1ns / 1ps

module lpg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  lpg_pkg::cmd_t   cmd,
	output logic            cmd_ready,
	output logic            empty,
	input  logic            pop,
	output lpg_pkg::coord_t pixel_x,
	output lpg_pkg::coord_t pixel_y,
	output lpg_pkg::color_t pixel_color,
	output logic            last_pixel
);
	import lpg_pkg::*;

	state_t state_q, state_nxt;
	coord_t maj_q, min_q, maj1_q, dx_q, dy_q;
	logic   step_dn_q, steep_q;
	color_t color_q;
	err_t   err_q;
	logic   out_valid_q;

	logic   step_en;
	logic   at_end;
	err_t   err_dec;

	assign at_end  = maj_q == maj1_q;
	assign err_dec = err_q - ERR_W'({2'b00, dy_q});
	assign empty   = !out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_nxt = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (step_en && at_end) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		step_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd_ready = 1'b1;
			ST_DRAW: step_en = !out_valid_q || pop;
			default: begin
				cmd_ready = 1'b0;
				step_en   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (step_en) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// load a command, then advance one pixel per step
	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			maj_q     <= cmd.maj0;
			min_q     <= cmd.min0;
			maj1_q    <= cmd.maj1;
			dx_q      <= cmd.dx;
			dy_q      <= cmd.dy;
			step_dn_q <= cmd.step_dn;
			steep_q   <= cmd.steep;
			color_q   <= cmd.color;
			err_q     <= ERR_W'({2'b00, cmd.dx} >> 1);
		end else if (step_en) begin
			maj_q <= maj_q + 1'b1;
			if (err_dec < 0) begin
				min_q <= step_dn_q ? min_q - 1'b1 : min_q + 1'b1;
				err_q <= err_dec + ERR_W'({2'b00, dx_q});
			end else begin
				err_q <= err_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			pixel_x     <= steep_q ? min_q : maj_q;
			pixel_y     <= steep_q ? maj_q : min_q;
			pixel_color <= color_q;
			last_pixel  <= at_end;
		end
	end

endmodule

/* rtl/core/line_pixel_generator.sv */
`timescale 1ns / 1ps
// Bresenham line generator.
// Command channel: drive the two endpoints and the color with push high;
// the transaction completes on a clock edge where full is low.
// Pixel channel: while empty is low, pixel_x, pixel_y, pixel_color and
// last_pixel show the oldest pixel; pop high on such an edge takes it.
// Every line gives dx+1 pixels along its major axis in rising order,
// last_pixel set on the final one.
// Path: a command passes the front register, the command queue and the
// engine's load step, then its first pixel is registered at the output.
// Pacing: the engine loads one command, then steps a pixel whenever its
// output is free or popped, and takes the next only when the line ends.
// A two-entry command queue lets new commands enter while a line draws.
// Pixel order and values do not depend on stalls: when pop stays low the
// engine holds its pixel and the command queue fills, then full rises.
// Reset (arst_n low) drops all queued commands and pending pixels.
module line_pixel_generator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lpg_pkg::coord_t start_x,
	input  lpg_pkg::coord_t start_y,
	input  lpg_pkg::coord_t end_x,
	input  lpg_pkg::coord_t end_y,
	input  lpg_pkg::color_t line_color,
	output logic            empty,
	input  logic            pop,
	output lpg_pkg::coord_t pixel_x,
	output lpg_pkg::coord_t pixel_y,
	output lpg_pkg::color_t pixel_color,
	output logic            last_pixel
);
	import lpg_pkg::*;

	logic front_valid, q_full, q_empty, back_ready;
	cmd_t front_cmd, q_cmd;

	lpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.line_color (line_color),
		.cmd_valid  (front_valid),
		.cmd_full   (q_full),
		.cmd        (front_cmd)
	);

	lpg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_cmd),
		.q_full  (q_full),
		.rd_en   (back_ready),
		.rd_data (q_cmd),
		.q_empty (q_empty)
	);

	lpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (!q_empty),
		.cmd         (q_cmd),
		.cmd_ready   (back_ready),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("command queue full and empty at once");

	a_full_needs_queue: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("full raised while command queue has room");

	a_load_then_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(back_ready && !q_empty) |=> !back_ready)
		else $error("engine took a command but did not start drawing");

	a_pixel_needs_load: assert property (@(posedge clk) disable iff (!arst_n)
		(back_ready && empty) |=> empty)
		else $error("pixel produced while engine idle");

endmodule

/* tb/sv/line_pixel_checker.sv */
`timescale 1ns / 1ps

module line_pixel_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  lpg_pkg::coord_t start_x,
	input  lpg_pkg::coord_t start_y,
	input  lpg_pkg::coord_t end_x,
	input  lpg_pkg::coord_t end_y,
	input  lpg_pkg::color_t line_color,
	input  logic            empty,
	input  logic            pop,
	input  lpg_pkg::coord_t pixel_x,
	input  lpg_pkg::coord_t pixel_y,
	input  lpg_pkg::color_t pixel_color,
	input  logic            last_pixel,
	output int              mismatches,
	output int              pixels_due
);

	import lpg_pkg::*;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   last;
	} pixel_t;

	pixel_t pixel_q[$];
	int     errors;

	initial begin
		errors = 0;
		mismatches = 0;
		pixels_due = 0;
	end

	task automatic expect_line(input coord_t sx, input coord_t sy, input coord_t ex,
			input coord_t ey, input color_t col);
		int     ax, ay, bx, by, t, dx, dy, err, ystep, adx, ady;
		bit     steep;
		pixel_t p;
		ax = sx;
		ay = sy;
		bx = ex;
		by = ey;
		adx = (bx > ax) ? bx - ax : ax - bx;
		ady = (by > ay) ? by - ay : ay - by;
		steep = ady > adx;
		if (steep) begin
			t = ax; ax = ay; ay = t;
			t = bx; bx = by; by = t;
		end
		if (ax > bx) begin
			t = ax; ax = bx; bx = t;
			t = ay; ay = by; by = t;
		end
		dx = bx - ax;
		dy = (by > ay) ? by - ay : ay - by;
		err = dx / 2;
		ystep = (ay < by) ? 1 : -1;
		while (ax <= bx && pixel_q.size() < 1 << 20) begin
			p.x = steep ? coord_t'(ay) : coord_t'(ax);
			p.y = steep ? coord_t'(ax) : coord_t'(ay);
			p.color = col;
			p.last = (ax == bx);
			pixel_q.push_back(p);
			err -= dy;
			if (err < 0) begin
				ay += ystep;
				err += dx;
			end
			ax++;
		end
	endtask

	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n) begin
			if (push && !full)
				expect_line(start_x, start_y, end_x, end_y, line_color);
			if (pop && !empty) begin
				if (pixel_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: pixel with no transaction pending: x=%0d y=%0d color=%0h last=%b",
							$realtime, pixel_x, pixel_y, pixel_color, last_pixel);
				end else begin
					exp_px = pixel_q.pop_front();
					if (pixel_x !== exp_px.x || pixel_y !== exp_px.y ||
							pixel_color !== exp_px.color || last_pixel !== exp_px.last) begin
						errors++;
						if (errors <= 10)
							$display("%0t: expected x=%0d y=%0d color=%0h last=%b, got x=%0d y=%0d color=%0h last=%b",
								$realtime, exp_px.x, exp_px.y, exp_px.color, exp_px.last,
								pixel_x, pixel_y, pixel_color, last_pixel);
					end
				end
			end
		end
		mismatches <= errors;
		pixels_due <= pixel_q.size();
	end

endmodule

/* tb/sv/tb_line_pixel_generator.sv */
`timescale 1ns / 1ps

module tb_line_pixel_generator;

	import lpg_pkg::*;

	logic   clk;
	logic   arst_n;
	logic   push;
	logic   full;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	color_t line_color;
	logic   empty;
	logic   pop;
	coord_t pixel_x;
	coord_t pixel_y;
	color_t pixel_color;
	logic   last_pixel;
	int     mismatches;
	int     pixels_due;
	logic   rand_phase;
	int     burst_left;

	line_pixel_generator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.line_color  (line_color),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	line_pixel_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.line_color  (line_color),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel),
		.mismatches  (mismatches),
		.pixels_due  (pixels_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("line_pixel_generator: mismatch");
		$finish;
	end

	// Send one line command; hold push until the transaction, then maybe idle.
	task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
			input int col);
		push <= 1'b1;
		start_x <= coord_t'(sx);
		start_y <= coord_t'(sy);
		end_x <= coord_t'(ex);
		end_y <= coord_t'(ey);
		line_color <= color_t'(col);
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 10);
			if ($urandom_range(0, 3) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 40))
					@(posedge clk);
			end
		end
	endtask

	// Receiver: pattern segments, plus one long hold-off in the random phase.
	initial begin
		int  seg_left;
		int  seg_mode;
		int  hold_left;
		bit  hold_done;
		pop <= 1'b0;
		seg_left = 0;
		seg_mode = 0;
		hold_left = 0;
		hold_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (!hold_done && rand_phase) begin
				pop <= 1'b0;
				hold_left = 400;
				hold_done = 1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(1, 200);
					seg_mode = $urandom_range(0, 2);
				end
				seg_left--;
				case (seg_mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin
		int sx, sy, ex, ey, kind;
		arst_n = 1'b0;
		push <= 1'b0;
		start_x <= '0;
		start_y <= '0;
		end_x <= '0;
		end_y <= '0;
		line_color <= '0;
		rand_phase <= 1'b0;
		burst_left = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		draw_line(0, 0, 0, 0, 8'h00);
		draw_line(63, 63, 63, 63, 8'hFF);
		draw_line(0, 0, 63, 0, 8'hAA);
		draw_line(63, 0, 0, 0, 8'h55);
		draw_line(0, 0, 0, 63, 8'h0F);
		draw_line(0, 63, 0, 0, 8'hF0);
		draw_line(0, 0, 63, 63, 8'h01);
		draw_line(63, 0, 0, 63, 8'h80);
		draw_line(63, 63, 0, 0, 8'h7F);
		draw_line(0, 63, 63, 0, 8'hFE);
		draw_line(10, 5, 3, 20, 8'h12);
		draw_line(5, 3, 40, 10, 8'h34);
		draw_line(40, 10, 5, 3, 8'h56);
		draw_line(3, 40, 10, 5, 8'h78);
		draw_line(20, 30, 21, 31, 8'h9A);
		draw_line(20, 30, 19, 29, 8'hBC);
		draw_line(7, 9, 8, 9, 8'hDE);
		draw_line(7, 9, 7, 10, 8'h3C);
		draw_line(0, 31, 63, 32, 8'hC3);
		draw_line(31, 0, 32, 63, 8'h5A);
		draw_line(42, 21, 21, 42, 8'hA5);

		rand_phase <= 1'b1;
		for (int i = 0; i < 200; i++) begin
			kind = $urandom_range(0, 9);
			sx = $urandom_range(0, 63);
			sy = $urandom_range(0, 63);
			if (kind < 5) begin
				ex = $urandom_range(0, 63);
				ey = $urandom_range(0, 63);
			end else if (kind < 9) begin
				ex = sx + int'($urandom_range(0, 12)) - 6;
				ey = sy + int'($urandom_range(0, 12)) - 6;
				ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
				ey = (ey < 0) ? 0 : (ey > 63) ? 63 : ey;
			end else begin
				sx = $urandom_range(0, 1) * 63;
				sy = $urandom_range(0, 1) * 63;
				ex = $urandom_range(0, 1) * 63;
				ey = $urandom_range(0, 1) * 63;
			end
			draw_line(sx, sy, ex, ey, $urandom_range(0, 255));
		end
		push <= 1'b0;

		@(posedge clk);
		while (pixels_due != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		if (mismatches == 0 && pixels_due == 0)
			$display("line_pixel_generator: match");
		else
			$display("line_pixel_generator: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/lpg_pkg.sv
rtl/core/lpg_front.sv
rtl/core/lpg_queue.sv
rtl/core/lpg_back.sv
rtl/core/line_pixel_generator.sv
tb/sv/line_pixel_checker.sv
tb/sv/tb_line_pixel_generator.sv
